FILE: sv/cleb_pkg.sv
`default_nettype none
package cleb_pkg;

    localparam int BYTE_W     = 8;
    localparam int STATUS_W   = 3;
    localparam int M_TDATA_W  = 16;
    localparam int M_TDATA_PAD = M_TDATA_W - STATUS_W - BYTE_W;
    localparam int CFG_ADDR_W = 2;

    localparam logic [BYTE_W-1:0] LEFT_KEY_RST    = 8'd60;
    localparam logic [BYTE_W-1:0] RIGHT_KEY_RST   = 8'd62;
    localparam logic [BYTE_W-1:0] DELETE_KEY_RST  = 8'd45;
    localparam logic [BYTE_W-1:0] CURSOR_MARK_RST = 8'd124;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_NO_LEFT,
        ST_NO_RIGHT,
        ST_NO_DELETE,
        ST_FULL
    } status_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_LEFT_KEY,
        CFG_RIGHT_KEY,
        CFG_DELETE_KEY,
        CFG_CURSOR_MARK
    } cfg_idx_t;

    typedef struct packed {
        logic [BYTE_W-1:0] left_key;
        logic [BYTE_W-1:0] right_key;
        logic [BYTE_W-1:0] delete_key;
        logic [BYTE_W-1:0] cursor_mark;
    } cfg_t;

    typedef enum logic [1:0] {
        STK_HOLD,
        STK_PUSH,
        STK_POP,
        STK_ROT
    } stk_op_t;

    typedef struct packed {
        stk_op_t           op;
        logic [BYTE_W-1:0] data;
    } stk_ctrl_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GATHER,
        S_EMITL,
        S_MARK,
        S_EMITR
    } state_t;

endpackage
`default_nettype wire

FILE: sv/cleb_cell.sv
`default_nettype none
module cleb_cell
    import cleb_pkg::*;
(
    input  wire logic              aclk,
    input  wire stk_op_t           op,
    input  wire logic              is_tail,
    input  wire logic [BYTE_W-1:0] from_top,
    input  wire logic [BYTE_W-1:0] from_deep,
    input  wire logic [BYTE_W-1:0] wrap_data,
    output logic      [BYTE_W-1:0] data
);

    logic [BYTE_W-1:0] data_reg;
    logic [BYTE_W-1:0] data_next;

    always_comb begin
        case (op)
            STK_PUSH: data_next = from_top;
            STK_POP:  data_next = from_deep;
            STK_ROT:  data_next = is_tail ? wrap_data : from_deep;
            default:  data_next = data_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule
`default_nettype wire

FILE: sv/cleb_stack.sv
`default_nettype none
module cleb_stack
    import cleb_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire stk_ctrl_t                    ctrl,
    output logic [BYTE_W-1:0]                 top_data,
    output logic [$clog2(CAPACITY+1)-1:0]     count
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [BYTE_W-1:0] cell_data [CAPACITY];
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;

    // cell 0 is the top of the stack, next to the cursor
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [BYTE_W-1:0] from_top;
        logic [BYTE_W-1:0] from_deep;

        if (i == 0) begin : g_first
            assign from_top = ctrl.data;
        end else begin : g_mid
            assign from_top = cell_data[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign from_deep = cell_data[i];
        end else begin : g_inner
            assign from_deep = cell_data[i+1];
        end

        cleb_cell u_cell (
            .aclk      (aclk),
            .op        (ctrl.op),
            .is_tail   (count_reg == CW'(i + 1)),
            .from_top  (from_top),
            .from_deep (from_deep),
            .wrap_data (cell_data[0]),
            .data      (cell_data[i])
        );
    end

    always_comb begin
        case (ctrl.op)
            STK_PUSH: count_next = count_reg + 1'b1;
            STK_POP:  count_next = count_reg - 1'b1;
            default:  count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    assign top_data = cell_data[0];
    assign count    = count_reg;

endmodule
`default_nettype wire

FILE: sv/cleb_ctrl.sv
`default_nettype none
module cleb_ctrl
    import cleb_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire cfg_t                          cfg,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [BYTE_W-1:0]             s_tdata,
    input  wire logic                          s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [M_TDATA_W-1:0]               m_tdata,
    output logic                               m_tuser,
    output logic                               m_tlast,
    output stk_ctrl_t                          left_ctrl,
    output stk_ctrl_t                          right_ctrl,
    input  wire logic [BYTE_W-1:0]             left_top,
    input  wire logic [BYTE_W-1:0]             right_top,
    input  wire logic [$clog2(CAPACITY+1)-1:0] left_count,
    input  wire logic [$clog2(CAPACITY+1)-1:0] right_count
);

    localparam int CW = $clog2(CAPACITY + 1);

    state_t            state_reg, state_next;
    logic [CW-1:0]     lsave_reg, lsave_next;
    logic [CW-1:0]     cnt_reg, cnt_next;

    logic              out_valid_reg, out_valid_next;
    status_t           out_status_reg, out_status_next;
    logic              out_text_reg, out_text_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic              out_last_reg, out_last_next;

    logic              out_free;
    logic              accept;
    logic [CW:0]       total;
    status_t           key_status;
    stk_op_t           key_left_op;
    stk_op_t           key_right_op;
    logic [BYTE_W-1:0] key_left_data;

    assign out_free = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign total    = {1'b0, left_count} + {1'b0, right_count};

    // key decode, left key wins over right key, right over delete
    always_comb begin
        key_status    = ST_OK;
        key_left_op   = STK_HOLD;
        key_right_op  = STK_HOLD;
        key_left_data = s_tdata;
        if (s_tdata == cfg.left_key) begin
            if (left_count == '0 || right_count >= CW'(CAPACITY)) begin
                key_status = ST_NO_LEFT;
            end else begin
                key_left_op  = STK_POP;
                key_right_op = STK_PUSH;
            end
        end else if (s_tdata == cfg.right_key) begin
            if (right_count == '0 || left_count >= CW'(CAPACITY)) begin
                key_status = ST_NO_RIGHT;
            end else begin
                key_right_op  = STK_POP;
                key_left_op   = STK_PUSH;
                key_left_data = right_top;
            end
        end else if (s_tdata == cfg.delete_key) begin
            if (left_count == '0) begin
                key_status = ST_NO_DELETE;
            end else begin
                key_left_op = STK_POP;
            end
        end else begin
            if (total >= (CW+1)'(CAPACITY) || left_count >= CW'(CAPACITY)) begin
                key_status = ST_FULL;
            end else begin
                key_left_op = STK_PUSH;
            end
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        lsave_next = lsave_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept && s_tuser) begin
                    lsave_next = left_count;
                    state_next = S_GATHER;
                end
            end
            S_GATHER: begin
                if (left_count == '0) begin
                    state_next = S_EMITL;
                end
            end
            S_EMITL: begin
                if (left_count == lsave_reg) begin
                    state_next = S_MARK;
                end
            end
            S_MARK: begin
                if (out_free) begin
                    cnt_next   = right_count;
                    state_next = (right_count == '0) ? S_IDLE : S_EMITR;
                end
            end
            S_EMITR: begin
                if (out_free) begin
                    cnt_next = cnt_reg - 1'b1;
                    if (cnt_reg == CW'(1)) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_tready        = 1'b0;
        left_ctrl       = '{op: STK_HOLD, data: right_top};
        right_ctrl      = '{op: STK_HOLD, data: left_top};
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_text_next   = out_text_reg;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;
        case (state_reg)
            S_IDLE: begin
                s_tready = out_free;
                if (s_tvalid && out_free && !s_tuser) begin
                    left_ctrl.op    = key_left_op;
                    left_ctrl.data  = key_left_data;
                    right_ctrl.op   = key_right_op;
                    out_valid_next  = 1'b1;
                    out_status_next = key_status;
                    out_text_next   = 1'b0;
                    out_byte_next   = '0;
                    out_last_next   = 1'b1;
                end
            end
            S_GATHER: begin
                if (left_count != '0) begin
                    left_ctrl.op  = STK_POP;
                    right_ctrl.op = STK_PUSH;
                end
            end
            S_EMITL: begin
                if (left_count != lsave_reg && out_free) begin
                    right_ctrl.op   = STK_POP;
                    left_ctrl.op    = STK_PUSH;
                    out_valid_next  = 1'b1;
                    out_status_next = ST_OK;
                    out_text_next   = 1'b1;
                    out_byte_next   = right_top;
                    out_last_next   = 1'b0;
                end
            end
            S_MARK: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_OK;
                    out_text_next   = 1'b1;
                    out_byte_next   = cfg.cursor_mark;
                    out_last_next   = (right_count == '0);
                end
            end
            S_EMITR: begin
                if (out_free) begin
                    right_ctrl.op   = STK_ROT;
                    out_valid_next  = 1'b1;
                    out_status_next = ST_OK;
                    out_text_next   = 1'b1;
                    out_byte_next   = right_top;
                    out_last_next   = (cnt_reg == CW'(1));
                end
            end
            default: s_tready = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            lsave_reg     <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            lsave_reg     <= lsave_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_status_reg <= out_status_next;
        out_text_reg   <= out_text_next;
        out_byte_reg   <= out_byte_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{M_TDATA_PAD{1'b0}}, out_byte_reg, out_status_reg};
    assign m_tuser  = out_text_reg;
    assign m_tlast  = out_last_reg;

endmodule
`default_nettype wire

FILE: sv/cursor_line_editor_buffer.sv
// key transaction: result valid in the cycle after acceptance, one key per cycle
//   while the result side keeps up
// readout: L + R + 1 results, L and R being the character counts left and right
//   of the cursor; the left chain is shifted over to the right chain and back,
//   one cell step per cycle while the result side keeps up
// reset: synchronous active-low aresetn empties both chains and restores the keys
`default_nettype none
module cursor_line_editor_buffer
    import cleb_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [BYTE_W-1:0]     cfg_wdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [BYTE_W-1:0]     s_tdata,   // key
    input  wire logic                  s_tuser,   // command
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,   // status, text_byte, zero pad
    output logic                       m_tuser,   // is_text
    output logic                       m_tlast
);

    localparam int CW = $clog2(CAPACITY + 1);

    cfg_t              cfg_reg;
    cfg_t              cfg_next;
    stk_ctrl_t         left_ctrl;
    stk_ctrl_t         right_ctrl;
    logic [BYTE_W-1:0] left_top;
    logic [BYTE_W-1:0] right_top;
    logic [CW-1:0]     left_count;
    logic [CW-1:0]     right_count;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_addr))
                CFG_LEFT_KEY:    cfg_next.left_key    = cfg_wdata;
                CFG_RIGHT_KEY:   cfg_next.right_key   = cfg_wdata;
                CFG_DELETE_KEY:  cfg_next.delete_key  = cfg_wdata;
                CFG_CURSOR_MARK: cfg_next.cursor_mark = cfg_wdata;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{left_key: LEFT_KEY_RST, right_key: RIGHT_KEY_RST,
                         delete_key: DELETE_KEY_RST, cursor_mark: CURSOR_MARK_RST};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    cleb_stack #(.CAPACITY(CAPACITY)) u_left (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (left_ctrl),
        .top_data (left_top),
        .count    (left_count)
    );

    cleb_stack #(.CAPACITY(CAPACITY)) u_right (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (right_ctrl),
        .top_data (right_top),
        .count    (right_count)
    );

    cleb_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .left_ctrl   (left_ctrl),
        .right_ctrl  (right_ctrl),
        .left_top    (left_top),
        .right_top   (right_top),
        .left_count  (left_count),
        .right_count (right_count)
    );

endmodule
`default_nettype wire

FILE: sv/cleb_checker.sv
`default_nettype none
module cleb_checker
    import cleb_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic                  s_tuser,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [M_TDATA_W-1:0]  m_tdata,
    input wire logic                  m_tuser,
    input wire logic                  m_tlast
);

    // stalled result stays
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // key transaction gives its single result in the next cycle
    a_key_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tuser |=> m_tvalid && m_tlast && !m_tuser)
        else $error("key result missing");

    // readout blocks further input right after acceptance
    a_readout_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser |=> !s_tready)
        else $error("input taken during readout");

    // key results carry no text byte
    a_key_no_text: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[10:3] == 8'd0 && m_tlast)
        else $error("key result with text byte");

    // text results always report ok
    a_text_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[2:0] == ST_OK)
        else $error("text result with error status");

endmodule

bind cursor_line_editor_buffer cleb_checker u_cleb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
`default_nettype wire
